/* src/camera_sensor_register_map_assert.svh */
// assertion macros for the register map modules, included by the back end
`ifndef CAMERA_SENSOR_REGISTER_MAP_ASSERT_SVH
`define CAMERA_SENSOR_REGISTER_MAP_ASSERT_SVH
`ifndef ASSERT_OFF
`define CSRM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csrm assertion failed");
`define CSRM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csrm assertion failed");
`else
`define CSRM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CSRM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* src/csrm_pkg.sv */
`timescale 1ns / 1ps
package csrm_pkg;

  localparam int MEM_BYTES = 16384;
  localparam int MEM_AW = $clog2(MEM_BYTES);

  localparam logic [6:0] SENSOR_DEV = 7'h1A;
  localparam logic [15:0] ADDR_MODE = 16'h3000;
  localparam logic [15:0] ADDR_MDSEL = 16'h3004;
  localparam logic [15:0] ADDR_DEPTH = 16'h306B;
  localparam logic [15:0] ADDR_VCUT = 16'h30E2;
  localparam logic [7:0] DEPTH_12BIT = 8'h07;
  localparam logic [7:0] MDSEL_HALF = 8'd2;
  localparam logic [7:0] MDSEL_THIRD = 8'd3;

  localparam int WIDTH_MAX = 3840;
  localparam logic [11:0] WIDTH_FULL = 12'(WIDTH_MAX);
  localparam logic [11:0] WIDTH_HALF = 12'(WIDTH_MAX / 2);
  localparam logic [11:0] WIDTH_THIRD = 12'(WIDTH_MAX / 3);
  localparam logic [11:0] HEIGHT_FULL = 12'd2160;
  localparam int DIV_BITS = 12;
  localparam logic [3:0] BITS_10 = 4'd10;
  localparam logic [3:0] BITS_12 = 4'd12;
  localparam int META_BASE = 175;
  localparam int META_EXTRA = 35;
  localparam logic [7:0] META_10 = 8'(((META_BASE + 7) / 8) * 8);
  localparam logic [7:0] META_12 = 8'(((META_BASE + META_EXTRA + 7) / 8) * 8);

  typedef enum logic [1:0] {
    FN_WRITE,
    FN_READ,
    FN_SHORT,
    FN_UNUSED
  } func_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_ADDR,
    ST_WR_FAIL,
    ST_RD_FAIL
  } status_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_WRITE,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              access;
    status_t           status;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        wdata;
  } req_t;

  typedef struct packed {
    logic [7:0] mdsel;
    logic [7:0] depth;
    logic [7:0] vcut;
  } geom_cfg_t;

  typedef struct packed {
    logic [11:0] width;
    logic [11:0] height;
    logic [3:0]  bits;
    logic [12:0] line_bytes;
    logic [16:0] image_start;
    logic [23:0] frame_length;
  } geom_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_MEM
  } back_state_t;

  typedef enum logic [2:0] {
    G_IDLE,
    G_DIV,
    G_MUL1,
    G_MUL2,
    G_SUM
  } geom_state_t;

endpackage

/* src/csrm_front.sv */
`timescale 1ns / 1ps
module csrm_front (
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [63:0]     in_tdata,
  input  logic [1:0]      in_tuser,
  input  logic            run_en,
  input  logic            q_full,
  output logic            push,
  output csrm_pkg::req_t  push_req
);
  import csrm_pkg::*;

  logic [6:0]  device_address;
  logic [15:0] register_address;
  logic [14:0] byte_count;
  logic [13:0] byte_index;
  logic [7:0]  write_data;
  func_t       fn;
  logic [17:0] wr_end;
  logic [17:0] rd_end;
  logic [16:0] addr;
  logic        in_range;

  assign device_address   = in_tdata[6:0];
  assign register_address = in_tdata[22:7];
  assign byte_count       = in_tdata[37:23];
  assign byte_index       = in_tdata[51:38];
  assign write_data       = in_tdata[59:52];
  assign fn               = func_t'(in_tuser);

  assign in_tready = run_en && !q_full;
  assign push      = in_tvalid && in_tready;

  assign wr_end   = 18'(register_address) + 18'(byte_count) + 18'd2;
  assign rd_end   = 18'(register_address) + 18'(byte_count);
  assign addr     = 17'(register_address) + 17'(byte_index);
  assign in_range = (15'(byte_index) < byte_count) && (18'(addr) < 18'(MEM_BYTES));

  always_comb begin
    push_req.op     = OP_NONE;
    push_req.access = 1'b0;
    push_req.status = ST_OK;
    push_req.addr   = addr[MEM_AW-1:0];
    push_req.wdata  = write_data;
    case (fn)
      FN_WRITE: begin
        if (device_address == SENSOR_DEV) begin
          if (wr_end > 18'(MEM_BYTES)) begin
            push_req.status = ST_WR_FAIL;
          end else begin
            push_req.op     = OP_WRITE;
            push_req.access = in_range;
          end
        end
      end
      FN_READ: begin
        if (device_address == SENSOR_DEV) begin
          if (rd_end > 18'(MEM_BYTES)) begin
            push_req.status = ST_RD_FAIL;
          end else begin
            push_req.op     = OP_READ;
            push_req.access = in_range;
          end
        end
      end
      // short transaction and the unused code both report a bad address
      default: begin
        push_req.status = ST_BAD_ADDR;
      end
    endcase
  end

endmodule

/* src/csrm_queue.sv */
`timescale 1ns / 1ps
module csrm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  csrm_pkg::req_t push_req,
  input  logic           pop,
  output csrm_pkg::req_t head,
  output logic           full,
  output logic           empty
);
  import csrm_pkg::*;

  req_t       slot_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign head  = slot_r[rd_ptr_r];
  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

/* src/csrm_geom.sv */
`timescale 1ns / 1ps
module csrm_geom (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  csrm_pkg::geom_cfg_t cfg,
  output logic                busy,
  output csrm_pkg::geom_t     geom
);
  import csrm_pkg::*;

  geom_state_t state_r;
  geom_state_t state_nxt;
  logic [3:0]  bit_r;
  logic [3:0]  bit_nxt;
  logic [7:0]  rem_r;
  logic [7:0]  rem_nxt;
  logic [7:0]  vcut_r;
  logic [7:0]  vcut_nxt;
  logic [11:0] width_r;
  logic [11:0] width_nxt;
  logic [11:0] height_r;
  logic [11:0] height_nxt;
  logic [3:0]  bits_r;
  logic [3:0]  bits_nxt;
  logic [12:0] bpl_r;
  logic [12:0] bpl_nxt;
  logic [23:0] hb_r;
  logic [23:0] hb_nxt;
  logic [16:0] start_r;
  logic [16:0] start_nxt;
  logic [23:0] flen_r;
  logic [23:0] flen_nxt;

  logic [8:0]  rem_shift;
  logic        ge;
  logic [15:0] prod;
  logic [16:0] prod_up;
  logic [24:0] hb_full;

  assign busy = (state_r != G_IDLE);
  assign geom = '{width: width_r, height: height_r, bits: bits_r, line_bytes: bpl_r,
                  image_start: start_r, frame_length: flen_r};

  // restoring division of the full height by the vertical cut, one bit a cycle
  assign rem_shift = {rem_r, HEIGHT_FULL[bit_r]};
  assign ge        = (rem_shift >= {1'b0, vcut_r});
  assign prod      = 16'(width_r) * 16'(bits_r);
  assign prod_up   = 17'(prod) + 17'd63;
  assign hb_full   = {13'd0, height_r} * {12'd0, bpl_r};

  always_comb begin
    state_nxt  = state_r;
    bit_nxt    = bit_r;
    rem_nxt    = rem_r;
    vcut_nxt   = vcut_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    bits_nxt   = bits_r;
    bpl_nxt    = bpl_r;
    hb_nxt     = hb_r;
    start_nxt  = start_r;
    flen_nxt   = flen_r;
    case (state_r)
      G_IDLE: begin
      end
      G_DIV: begin
        rem_nxt    = ge ? 8'(rem_shift - {1'b0, vcut_r}) : rem_shift[7:0];
        height_nxt = {height_r[10:0], ge};
        bit_nxt    = bit_r - 4'd1;
        if (bit_r == 4'd0) begin
          state_nxt = G_MUL1;
        end
      end
      G_MUL1: begin
        // round up to whole 64-bit words, then express in bytes
        bpl_nxt   = {prod_up[15:6], 3'b000};
        state_nxt = G_MUL2;
      end
      G_MUL2: begin
        hb_nxt = hb_full[23:0];
        if (bits_r == BITS_12) begin
          start_nxt = 17'(META_12) + {bpl_r, 4'b0000};
        end else begin
          start_nxt = 17'(META_10) + 17'({bpl_r, 3'b000});
        end
        state_nxt = G_SUM;
      end
      G_SUM: begin
        flen_nxt  = 24'(start_r) + hb_r;
        state_nxt = G_IDLE;
      end
      default: begin
        state_nxt = G_IDLE;
      end
    endcase

    // a new start restarts from the latest register values
    if (start) begin
      vcut_nxt = cfg.vcut;
      rem_nxt  = 8'd0;
      bit_nxt  = 4'(DIV_BITS - 1);
      if (cfg.mdsel == MDSEL_HALF) begin
        width_nxt = WIDTH_HALF;
      end else if (cfg.mdsel >= MDSEL_THIRD) begin
        width_nxt = WIDTH_THIRD;
      end else begin
        width_nxt = WIDTH_FULL;
      end
      bits_nxt = (cfg.depth == DEPTH_12BIT) ? BITS_12 : BITS_10;
      if (cfg.vcut == 8'd0) begin
        height_nxt = HEIGHT_FULL;
        state_nxt  = G_MUL1;
      end else begin
        height_nxt = 12'd0;
        state_nxt  = G_DIV;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bit_r    <= bit_nxt;
    rem_r    <= rem_nxt;
    vcut_r   <= vcut_nxt;
    width_r  <= width_nxt;
    height_r <= height_nxt;
    bits_r   <= bits_nxt;
    bpl_r    <= bpl_nxt;
    hb_r     <= hb_nxt;
    start_r  <= start_nxt;
    flen_r   <= flen_nxt;
  end

endmodule

/* src/csrm_back.sv */
`timescale 1ns / 1ps
`include "camera_sensor_register_map_assert.svh"
module csrm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  csrm_pkg::req_t      q_head,
  output logic                pop,
  output logic                run_en,
  output logic                geom_start,
  output csrm_pkg::geom_cfg_t geom_cfg,
  input  logic                geom_busy,
  input  csrm_pkg::geom_t     geom,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [95:0]         out_tdata,
  output logic [1:0]          out_tuser
);
  import csrm_pkg::*;

  logic [7:0] mem [MEM_BYTES];

  back_state_t       state_r;
  back_state_t       state_nxt;
  logic [MEM_AW-1:0] clr_cnt_r;
  logic [MEM_AW-1:0] clr_cnt_nxt;
  req_t              cur_r;
  req_t              cur_nxt;
  logic [7:0]        mode_r;
  logic [7:0]        mode_nxt;
  logic [7:0]        mdsel_r;
  logic [7:0]        mdsel_nxt;
  logic [7:0]        depth_r;
  logic [7:0]        depth_nxt;
  logic [7:0]        vcut_r;
  logic [7:0]        vcut_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [95:0]       out_data_r;
  logic [95:0]       out_data_nxt;
  logic [1:0]        out_user_r;
  logic [1:0]        out_user_nxt;

  logic              mem_we;
  logic [MEM_AW-1:0] mem_addr;
  logic [7:0]        mem_wd;
  logic [7:0]        rd_q;
  logic [7:0]        read_byte;
  logic              streaming;

  assign run_en     = (state_r != B_CLEAR);
  assign geom_cfg   = '{mdsel: mdsel_nxt, depth: depth_nxt, vcut: vcut_nxt};
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign read_byte  = (cur_r.op == OP_READ && cur_r.access) ? rd_q : 8'd0;
  assign streaming  = (mode_r == 8'd0);

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    cur_nxt       = cur_r;
    mode_nxt      = mode_r;
    mdsel_nxt     = mdsel_r;
    depth_nxt     = depth_r;
    vcut_nxt      = vcut_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    pop           = 1'b0;
    geom_start    = 1'b0;
    mem_we        = 1'b0;
    mem_addr      = q_head.addr;
    mem_wd        = q_head.wdata;
    case (state_r)
      B_CLEAR: begin
        mem_we      = 1'b1;
        mem_addr    = clr_cnt_r;
        mem_wd      = (clr_cnt_r == ADDR_MODE[MEM_AW-1:0]) ? 8'd1 : 8'd0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == MEM_AW'(MEM_BYTES - 1)) begin
          geom_start = 1'b1;
          state_nxt  = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_empty && !out_valid_r) begin
          pop       = 1'b1;
          cur_nxt   = q_head;
          mem_we    = (q_head.op == OP_WRITE) && q_head.access;
          state_nxt = B_MEM;
          if (mem_we) begin
            // geometry bytes are mirrored so the report needs no memory reads
            if (q_head.addr == ADDR_MODE[MEM_AW-1:0]) begin
              mode_nxt = q_head.wdata;
            end
            if (q_head.addr == ADDR_MDSEL[MEM_AW-1:0]) begin
              mdsel_nxt  = q_head.wdata;
              geom_start = 1'b1;
            end
            if (q_head.addr == ADDR_DEPTH[MEM_AW-1:0]) begin
              depth_nxt  = q_head.wdata;
              geom_start = 1'b1;
            end
            if (q_head.addr == ADDR_VCUT[MEM_AW-1:0]) begin
              vcut_nxt   = q_head.wdata;
              geom_start = 1'b1;
            end
          end
        end
      end
      B_MEM: begin
        // keep reading the current request's byte while the geometry unit runs
        mem_addr = cur_r.addr;
        if (!geom_busy) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = cur_r.status;
          out_data_nxt  = {5'd0, geom.frame_length, geom.image_start, geom.line_bytes,
                           geom.bits, geom.height, geom.width, streaming, read_byte};
          state_nxt     = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_cnt_r   <= '0;
      mode_r      <= 8'd1;
      mdsel_r     <= 8'd0;
      depth_r     <= 8'd0;
      vcut_r      <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      mode_r      <= mode_nxt;
      mdsel_r     <= mdsel_nxt;
      depth_r     <= depth_nxt;
      vcut_r      <= vcut_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    rd_q <= mem[mem_addr];
  end

  `CSRM_ASSERT_IMP(a_no_pop_in_clear, clk, rst_n, state_r == B_CLEAR, !pop)
  `CSRM_ASSERT_IMP(a_pop_needs_free_out, clk, rst_n, pop, !out_valid_r && !q_empty)
  `CSRM_ASSERT_NXT(a_mem_done_loads, clk, rst_n, state_r == B_MEM && !geom_busy, out_valid_r)
  `CSRM_ASSERT_IMP(a_load_from_mem, clk, rst_n, $rose(out_valid_r), $past(state_r == B_MEM))

endmodule

/* src/camera_sensor_register_map.sv */
`timescale 1ns / 1ps
// channel   | dir | tdata fields (lsb first)                                   | tuser
// in_       | in  | device_address, register_address, byte_count, byte_index,  | func
//           |     | write_data                                                 |
// out_      | out | read_data, streaming, pixel_width, pixel_height,          | status
//           |     | pixel_bits, line_bytes, image_start, frame_length          |
// after reset a clearing pass writes all 16384 memory bytes, one a cycle, and no
// request is taken until it ends
// a request goes from the queue head to the output register by a memory access, then a
// result load
// a write to the mode select, bit depth or vertical cut byte reruns the geometry unit and
// holds the result load while it runs its bit-serial height divider and then its MUL1,
// MUL2 and SUM steps; the divider is skipped when the vertical cut byte is zero
// a two-entry queue lets requests arrive while the output register holds a result
module camera_sensor_register_map (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,  // device_address, register_address, byte_count,
                                 // byte_index, write_data
  input  logic [1:0]  in_tuser,  // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata, // read_data, streaming, pixel_width, pixel_height,
                                 // pixel_bits, line_bytes, image_start, frame_length
  output logic [1:0]  out_tuser  // status
);
  import csrm_pkg::*;

  req_t      push_req;
  req_t      q_head;
  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_empty;
  logic      run_en;
  logic      geom_start;
  logic      geom_busy;
  geom_cfg_t geom_cfg;
  geom_t     geom;

  csrm_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .run_en    (run_en),
    .q_full    (q_full),
    .push      (push),
    .push_req  (push_req)
  );

  csrm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  csrm_geom u_geom (
    .clk   (clk),
    .rst_n (rst_n),
    .start (geom_start),
    .cfg   (geom_cfg),
    .busy  (geom_busy),
    .geom  (geom)
  );

  csrm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .pop        (pop),
    .run_en     (run_en),
    .geom_start (geom_start),
    .geom_cfg   (geom_cfg),
    .geom_busy  (geom_busy),
    .geom       (geom),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
